// ===== rtl/pts_pkg.sv =====
// pts_pkg: shared types and constants of the priority task scheduler.
// No dependencies; used by pts_table and priority_task_scheduler_unit.
`default_nettype none

package pts_pkg;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_READY = 2'd1,
		SLOT_SUSP  = 2'd2
	} slot_state_t;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_ADD      = 3'd1,
		OP_SUSP_ID  = 3'd2,
		OP_RESUME   = 3'd3,
		OP_END      = 3'd4,
		OP_DELAY    = 3'd5,
		OP_SUSP_CUR = 3'd6
	} op_t;

	typedef struct packed {
		slot_state_t  state;
		logic [7:0]   prio;
		logic [31:0]  dstart;
		logic [15:0]  dlen;
	} slot_entry_t;

	localparam logic [3:0] TASK_COUNT_RST = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/pts_table.sv =====
// pts_table: task table memory, one read and one write port, registered read.
// Per-entry valid bits make unwritten slots read as an empty, zeroed entry.
// Depends on pts_pkg.
`default_nettype none

module pts_table #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      rd_en,
	input  wire [AW-1:0]             rd_addr,
	output pts_pkg::slot_entry_t     rd_data,
	input  wire                      wr_en,
	input  wire [AW-1:0]             wr_addr,
	input  pts_pkg::slot_entry_t     wr_data
);

	pts_pkg::slot_entry_t mem [DEPTH];
	pts_pkg::slot_entry_t rd_q;
	logic [DEPTH-1:0]     vld_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/priority_task_scheduler_unit.sv =====
// priority_task_scheduler_unit: task table sequencer with circular priority scan.
// Per item: an entry read and update (S_RD, with S_RD2 for resume) where the op needs
// one, then a priority scan (S_SCAN) or free-slot search (S_FIND) where the op needs
// one, then S_DONE, which registers the result beat.
// One item at a time; the scan reads one table entry per cycle through pts_table.
// Async reset: idle, running slot 0, task count 8, all slots empty (valid bits).
`default_nettype none

module priority_task_scheduler_unit #(
	parameter int MAX_TASKS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] task_id, [10:3] priority_req, [26:11] delay_ms, [58:27] now_ms, [63:59] zero
	input  wire  [63:0] s_axis_tdata,
	// [2:0] operation
	input  wire  [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [2:0] current_task, [5:3] added_task, [6] table_full, [7] rescheduled
	output logic [7:0]  m_axis_tdata,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [3:0]  cfg_data
);

	localparam int SW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int EW = (CW > 4) ? CW : 4;
	localparam int IW = (CW > 3) ? CW : 3;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_RD2  = 6'b000100,
		S_SCAN = 6'b001000,
		S_FIND = 6'b010000,
		S_DONE = 6'b100000
	} seq_state_t;

	seq_state_t           state_q, state_d;
	logic [3:0]           task_count_q;
	logic [EW-1:0]        tc_ext, eff_w;
	logic [CW-1:0]        eff_n;

	pts_pkg::op_t         op_q, in_op;
	logic [SW-1:0]        tgt_q;
	logic [7:0]           pri_q;
	logic signed [15:0]   dly_q;
	logic [31:0]          now_q;

	logic [SW-1:0]        running_q, added_q, best_q, rd_ptr_q, addr_s1, start_ptr, ptr_nx;
	logic [SW-1:0]        in_addr;
	logic [CW-1:0]        cnt_q, run_inc, ptr_inc;
	logic [7:0]           bestpri_q, pri_id_q;
	logic                 found_q, full_q, sched_q, dv_s1;
	logic                 out_valid_q;
	logic [7:0]           out_data_q;

	logic [2:0]           in_id;
	logic                 in_id_ok, s_acc;
	logic                 go_scan, go_find, issue, take, hit, expire, last;
	logic [31:0]          age;

	logic                 rd_en, wr_en;
	logic [SW-1:0]        rd_addr, wr_addr;
	pts_pkg::slot_entry_t ent, wr_data;

	pts_table #(
		.DEPTH (MAX_TASKS),
		.AW    (SW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ent),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign tc_ext = EW'(task_count_q);
	assign eff_w  = (tc_ext == '0) ? EW'(1) :
	                (tc_ext > EW'(MAX_TASKS)) ? EW'(MAX_TASKS) : tc_ext;
	assign eff_n  = CW'(eff_w);

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign in_op         = pts_pkg::op_t'(s_axis_tuser);
	assign in_id         = s_axis_tdata[2:0];
	assign in_id_ok      = IW'(in_id) < IW'(eff_n);
	assign in_addr       = ((in_op == pts_pkg::OP_SUSP_ID) || (in_op == pts_pkg::OP_RESUME)) ?
	                       SW'(in_id) : running_q;

	assign run_inc   = CW'(running_q) + CW'(1);
	assign start_ptr = (run_inc >= eff_n) ? '0 : SW'(run_inc);
	assign ptr_inc   = CW'(rd_ptr_q) + CW'(1);
	assign ptr_nx    = (ptr_inc >= eff_n) ? '0 : SW'(ptr_inc);

	// scan evaluation of the entry returned for addr_s1
	assign age    = now_q - ent.dstart;
	assign expire = (ent.state != pts_pkg::SLOT_EMPTY) && (ent.dlen != '0) &&
	                (age > {16'd0, ent.dlen});
	assign take   = (state_q == S_SCAN) && dv_s1 && (ent.state == pts_pkg::SLOT_READY) &&
	                (expire || (ent.dlen == '0)) && (!found_q || (ent.prio > bestpri_q));
	assign hit    = (state_q == S_FIND) && dv_s1 && (ent.state == pts_pkg::SLOT_EMPTY);
	assign issue  = ((state_q == S_SCAN) || (state_q == S_FIND)) && (cnt_q < eff_n);
	assign last   = (cnt_q == eff_n);

	always_comb begin
		state_d = state_q;
		go_scan = 1'b0;
		go_find = 1'b0;
		rd_en   = 1'b0;
		rd_addr = rd_ptr_q;
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = ent;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					case (in_op)
						pts_pkg::OP_TICK: begin
							go_scan = 1'b1;
							state_d = S_SCAN;
						end
						pts_pkg::OP_ADD: begin
							go_find = 1'b1;
							state_d = S_FIND;
						end
						pts_pkg::OP_SUSP_ID, pts_pkg::OP_RESUME: begin
							if (in_id_ok) begin
								rd_en   = 1'b1;
								rd_addr = in_addr;
								state_d = S_RD;
							end else begin
								state_d = S_DONE;
							end
						end
						pts_pkg::OP_END, pts_pkg::OP_DELAY, pts_pkg::OP_SUSP_CUR: begin
							rd_en   = 1'b1;
							rd_addr = running_q;
							state_d = S_RD;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_RD: begin
				wr_en   = 1'b1;
				wr_addr = tgt_q;
				case (op_q)
					pts_pkg::OP_SUSP_ID: begin
						if (ent.state == pts_pkg::SLOT_READY) begin
							wr_data.state = pts_pkg::SLOT_SUSP;
						end
						if (tgt_q == running_q) begin
							go_scan = 1'b1;
							state_d = S_SCAN;
						end else begin
							state_d = S_DONE;
						end
					end
					pts_pkg::OP_RESUME: begin
						if (ent.state == pts_pkg::SLOT_SUSP) begin
							wr_data.state = pts_pkg::SLOT_READY;
						end
						rd_en   = 1'b1;
						rd_addr = running_q;
						state_d = S_RD2;
					end
					pts_pkg::OP_END: begin
						wr_data.state = pts_pkg::SLOT_EMPTY;
						go_scan       = 1'b1;
						state_d       = S_SCAN;
					end
					pts_pkg::OP_DELAY: begin
						if (dly_q > 16'sd0) begin
							wr_data.dstart = now_q;
							wr_data.dlen   = $unsigned(dly_q);
							go_scan        = 1'b1;
							state_d        = S_SCAN;
						end else begin
							wr_data.dlen = '0;
							state_d      = S_DONE;
						end
					end
					pts_pkg::OP_SUSP_CUR: begin
						wr_data.state = pts_pkg::SLOT_SUSP;
						go_scan       = 1'b1;
						state_d       = S_SCAN;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_RD2: begin
				if (pri_id_q > ent.prio) begin
					go_scan = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				rd_en = issue;
				if (dv_s1 && expire) begin
					wr_en        = 1'b1;
					wr_data.dlen = '0;
				end
				if (last) begin
					state_d = S_DONE;
				end
			end
			S_FIND: begin
				rd_en = issue;
				if (hit) begin
					wr_en          = 1'b1;
					wr_data.state  = pts_pkg::SLOT_READY;
					wr_data.prio   = pri_q;
					wr_data.dlen   = '0;
					state_d        = S_DONE;
				end else if (last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q  <= in_op;
			tgt_q <= in_addr;
			pri_q <= s_axis_tdata[10:3];
			dly_q <= $signed(s_axis_tdata[26:11]);
			now_q <= s_axis_tdata[58:27];
		end
		if (state_q == S_RD) begin
			pri_id_q <= ent.prio;
		end
		addr_s1 <= rd_ptr_q;
		if (take) begin
			best_q    <= addr_s1;
			bestpri_q <= ent.prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			task_count_q <= pts_pkg::TASK_COUNT_RST;
			running_q    <= '0;
			added_q      <= '0;
			full_q       <= 1'b0;
			sched_q      <= 1'b0;
			found_q      <= 1'b0;
			rd_ptr_q     <= '0;
			cnt_q        <= '0;
			dv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			state_q <= state_d;
			dv_s1   <= issue;
			if (cfg_valid) begin
				task_count_q <= cfg_data;
			end
			if (s_acc) begin
				added_q <= '0;
				full_q  <= 1'b0;
				sched_q <= 1'b0;
			end
			if (issue) begin
				rd_ptr_q <= ptr_nx;
				cnt_q    <= cnt_q + CW'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (go_scan) begin
				sched_q  <= 1'b1;
				found_q  <= 1'b0;
				rd_ptr_q <= start_ptr;
				cnt_q    <= '0;
			end
			if (go_find) begin
				rd_ptr_q <= '0;
				cnt_q    <= '0;
			end
			if ((state_q == S_SCAN) && last) begin
				if (take) begin
					running_q <= addr_s1;
				end else if (found_q) begin
					running_q <= best_q;
				end
			end
			if (state_q == S_FIND) begin
				if (hit) begin
					added_q <= addr_s1;
				end else if (last) begin
					full_q <= 1'b1;
				end
			end
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {sched_q, full_q, 3'(added_q), 3'(running_q)};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign cfg_ready     = 1'b1;

`ifndef ASSERT_OFF
	a_scan_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("scan write-back collides with a read of the same slot");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en)
		else $error("table written while idle");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) || (state_q == S_FIND)) |-> (cnt_q <= eff_n))
		else $error("scan count overran the slots in use");

	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[6]) |-> (m_axis_tdata[5:3] == 3'd0))
		else $error("full table reported with an added slot");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && m_axis_tvalid && !m_axis_tready) |=> (state_q == S_DONE))
		else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire
